// ===== design/crs_pkg.sv =====
package crs_pkg;

   localparam int NODES = 64;
   localparam int ADDR_W = $clog2(NODES);
   localparam int CNT_W = 7;
   localparam int COORD_W = 32;
   localparam int NODE_W = 3 * COORD_W;
   localparam int PT_W = 22;
   localparam int T_FRAC = 16;
   localparam int P_W = COORD_W + 2;
   localparam int ACC_W = 40;
   localparam int PROD_W = ACC_W + T_FRAC + 1;
   localparam int CSR_IDX_W = 3;
   localparam int LAT = 11;

   localparam logic [PROD_W-1:0] RND_HALF = PROD_W'(1) << (T_FRAC - 1);

   typedef enum logic {
      OP_EVAL  = 1'b0,
      OP_WRITE = 1'b1
   } op_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CFG_NODE_COUNT = 3'd0,
      CFG_LINE_MODE  = 3'd1,
      CFG_LOOP_MODE  = 3'd2,
      CFG_OFFSET_X   = 3'd3,
      CFG_OFFSET_Y   = 3'd4,
      CFG_OFFSET_Z   = 3'd5
   } cfg_index_type;

   typedef enum logic [1:0] {
      MODE_CR,
      MODE_LINE,
      MODE_POINT,
      MODE_ZERO
   } mode_type;

   typedef struct packed {
      op_type                  kind;
      mode_type                mode;
      logic                    mir0;
      logic                    mir3;
      logic [3:0][ADDR_W-1:0]  addr;
      logic [ADDR_W-1:0]       waddr;
      logic [T_FRAC-1:0]       u;
      logic [NODE_W-1:0]       data;
   } cmd_type;

   typedef struct packed {
      logic              v;
      mode_type          mode;
      logic              mir0;
      logic              mir3;
      logic [T_FRAC-1:0] u;
   } fctl_type;

   typedef struct packed {
      logic              v;
      logic              half;
      logic              nooff;
      logic [T_FRAC-1:0] u;
   } bctl_type;

   function automatic logic signed [ACC_W-1:0] rnd(input logic signed [PROD_W-1:0] p);
      logic [PROD_W-1:0] t;
      t = p + RND_HALF;
      return t[T_FRAC +: ACC_W];
   endfunction

   function automatic logic signed [PROD_W-1:0] mulu(input logic signed [ACC_W-1:0] a,
                                                     input logic [T_FRAC-1:0] u);
      logic signed [PROD_W-1:0] ae;
      logic signed [PROD_W-1:0] ue;
      ae = PROD_W'(a);
      ue = signed'(PROD_W'(u));
      return ae * ue;
   endfunction

endpackage

// ===== design/crs_front.sv =====
module crs_front (
   input  logic                        req_op,
   input  logic [5:0]                  req_node_index,
   input  logic signed [31:0]          req_node_x,
   input  logic signed [31:0]          req_node_y,
   input  logic signed [31:0]          req_node_z,
   input  logic [21:0]                 req_param_t,
   input  logic [crs_pkg::CNT_W-1:0]   node_count,
   input  logic                        line_mode,
   input  logic                        loop_mode,
   output crs_pkg::cmd_type            cmd
);

   localparam logic [crs_pkg::CNT_W-1:0] NODES_C = crs_pkg::CNT_W'(crs_pkg::NODES);
   localparam logic [crs_pkg::CNT_W-1:0] ONE = crs_pkg::CNT_W'(1);
   localparam logic [crs_pkg::CNT_W-1:0] TWO = crs_pkg::CNT_W'(2);

   logic [crs_pkg::CNT_W-1:0] n;
   logic [crs_pkg::CNT_W-1:0] m;
   logic [crs_pkg::CNT_W-1:0] seg;
   logic [crs_pkg::CNT_W-1:0] i;
   logic [crs_pkg::CNT_W-1:0] j;
   logic                      wrap;

   always_comb begin
      n = (node_count > NODES_C) ? NODES_C : node_count;
      m = n - ONE;
      seg = crs_pkg::CNT_W'(req_param_t[crs_pkg::PT_W-1:crs_pkg::T_FRAC]);
      i = (seg > m) ? m : seg;
      j = ((i + ONE) > m) ? m : (i + ONE);
      wrap = loop_mode && (m >= TWO);

      cmd = '0;
      cmd.kind = (req_op == crs_pkg::OP_WRITE) ? crs_pkg::OP_WRITE : crs_pkg::OP_EVAL;
      cmd.waddr = crs_pkg::ADDR_W'(req_node_index);
      cmd.data = {req_node_z, req_node_y, req_node_x};
      cmd.u = req_param_t[crs_pkg::T_FRAC-1:0];
      cmd.addr[1] = i[crs_pkg::ADDR_W-1:0];
      cmd.addr[2] = j[crs_pkg::ADDR_W-1:0];

      if (i != '0) begin
         cmd.addr[0] = crs_pkg::ADDR_W'(i - ONE);
      end else if (wrap) begin
         cmd.addr[0] = crs_pkg::ADDR_W'(m - ONE);
      end else begin
         cmd.addr[0] = i[crs_pkg::ADDR_W-1:0];
         cmd.mir0 = 1'b1;
      end

      if ((i + TWO) <= m) begin
         cmd.addr[3] = crs_pkg::ADDR_W'(i + TWO);
      end else if (wrap) begin
         cmd.addr[3] = crs_pkg::ADDR_W'(ONE);
      end else begin
         cmd.addr[3] = j[crs_pkg::ADDR_W-1:0];
         cmd.mir3 = 1'b1;
      end

      if (n == '0) begin
         cmd.mode = crs_pkg::MODE_ZERO;
      end else if (n == ONE) begin
         cmd.mode = crs_pkg::MODE_POINT;
      end else if (line_mode) begin
         cmd.mode = crs_pkg::MODE_LINE;
      end else begin
         cmd.mode = crs_pkg::MODE_CR;
      end
   end

endmodule

// ===== design/crs_queue.sv =====
module crs_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  crs_pkg::cmd_type push_cmd,
   input  logic             pop,
   output crs_pkg::cmd_type head,
   output logic             not_empty,
   output logic             full
);

   crs_pkg::cmd_type entry_ff [2];
   logic             wr_ptr_ff;
   logic             wr_ptr_in;
   logic             rd_ptr_ff;
   logic             rd_ptr_in;
   logic [1:0]       count_ff;
   logic [1:0]       count_in;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   assign head = entry_ff[rd_ptr_ff];
   assign not_empty = (count_ff != '0);
   assign full = (count_ff == 2'd2);

endmodule

// ===== design/crs_back.sv =====
module crs_back (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      pop,
   input  crs_pkg::cmd_type          cmd,
   input  logic signed [31:0]        offset_x,
   input  logic signed [31:0]        offset_y,
   input  logic signed [31:0]        offset_z,
   output logic                      rsp_valid,
   output logic signed [31:0]        rsp_pos_x,
   output logic signed [31:0]        rsp_pos_y,
   output logic signed [31:0]        rsp_pos_z
);

   localparam int SW = crs_pkg::ACC_W + 1;
   localparam logic signed [SW-1:0] SAT_HI = SW'(64'sd2147483647);
   localparam logic signed [SW-1:0] SAT_LO = -SW'(64'sd2147483648);

   logic [crs_pkg::NODE_W-1:0] node_mem [4][crs_pkg::NODES];

   logic [crs_pkg::NODE_W-1:0] rd_ff [4];
   crs_pkg::fctl_type           f0_ff;
   crs_pkg::fctl_type           f0_in;
   crs_pkg::fctl_type           f1_ff;

   logic signed [crs_pkg::P_W-1:0] p_ff [3][4];
   logic signed [crs_pkg::P_W-1:0] p_in [3][4];

   logic signed [crs_pkg::ACC_W-1:0] a_ff [3][4];
   logic signed [crs_pkg::ACC_W-1:0] a_in [3][4];
   crs_pkg::bctl_type                 c_in;
   crs_pkg::bctl_type                 ctl_ff [7];

   logic signed [crs_pkg::PROD_W-1:0] m1_ff [3];
   logic signed [crs_pkg::ACC_W-1:0]  m1a_ff [3][3];
   logic signed [crs_pkg::ACC_W-1:0]  h1_ff [3];
   logic signed [crs_pkg::ACC_W-1:0]  h1a_ff [3][2];
   logic signed [crs_pkg::PROD_W-1:0] m2_ff [3];
   logic signed [crs_pkg::ACC_W-1:0]  m2a_ff [3][2];
   logic signed [crs_pkg::ACC_W-1:0]  h2_ff [3];
   logic signed [crs_pkg::ACC_W-1:0]  h2a_ff [3];
   logic signed [crs_pkg::PROD_W-1:0] m3_ff [3];
   logic signed [crs_pkg::ACC_W-1:0]  m3a_ff [3];
   logic signed [crs_pkg::ACC_W-1:0]  h3_ff [3];

   logic signed [31:0]       offs [3];
   logic signed [31:0]       pos_in [3];
   logic signed [31:0]       pos_ff [3];
   logic                     valid_ff;

   always_ff @(posedge clock) begin
      for (int k = 0; k < 4; k++) begin
         if (pop && (cmd.kind == crs_pkg::OP_WRITE)) begin
            node_mem[k][cmd.waddr] <= cmd.data;
         end
         rd_ff[k] <= node_mem[k][cmd.addr[k]];
      end
   end

   always_comb begin
      f0_in.v = pop && (cmd.kind == crs_pkg::OP_EVAL);
      f0_in.mode = cmd.mode;
      f0_in.mir0 = cmd.mir0;
      f0_in.mir3 = cmd.mir3;
      f0_in.u = cmd.u;
   end

   always_comb begin
      logic signed [crs_pkg::P_W-1:0] x [4];
      for (int c = 0; c < 3; c++) begin
         for (int k = 0; k < 4; k++) begin
            x[k] = crs_pkg::P_W'(signed'(rd_ff[k][c*crs_pkg::COORD_W +: crs_pkg::COORD_W]));
         end
         p_in[c][1] = x[1];
         p_in[c][2] = x[2];
         p_in[c][0] = f0_ff.mir0 ? ((x[1] <<< 1) - x[2]) : x[0];
         p_in[c][3] = f0_ff.mir3 ? ((x[2] <<< 1) - x[1]) : x[3];
      end
   end

   always_comb begin
      logic signed [crs_pkg::ACC_W-1:0] q [4];
      c_in.v = f1_ff.v;
      c_in.u = f1_ff.u;
      c_in.half = (f1_ff.mode == crs_pkg::MODE_CR);
      c_in.nooff = (f1_ff.mode == crs_pkg::MODE_ZERO);
      for (int c = 0; c < 3; c++) begin
         for (int k = 0; k < 4; k++) begin
            q[k] = crs_pkg::ACC_W'(p_ff[c][k]);
         end
         unique case (f1_ff.mode)
            crs_pkg::MODE_CR: begin
               a_in[c][0] = q[1] <<< 1;
               a_in[c][1] = q[2] - q[0];
               a_in[c][2] = (q[0] <<< 1) - ((q[1] <<< 2) + q[1]) + (q[2] <<< 2) - q[3];
               a_in[c][3] = q[3] - q[0] + ((q[1] <<< 1) + q[1]) - ((q[2] <<< 1) + q[2]);
            end
            crs_pkg::MODE_LINE: begin
               a_in[c][0] = q[1];
               a_in[c][1] = q[2] - q[1];
               a_in[c][2] = '0;
               a_in[c][3] = '0;
            end
            crs_pkg::MODE_POINT: begin
               a_in[c][0] = q[1];
               a_in[c][1] = '0;
               a_in[c][2] = '0;
               a_in[c][3] = '0;
            end
            default: begin
               a_in[c] = '{default: '0};
            end
         endcase
      end
   end

   assign offs[0] = offset_x;
   assign offs[1] = offset_y;
   assign offs[2] = offset_z;

   always_comb begin
      logic signed [crs_pkg::ACC_W-1:0] s;
      logic signed [crs_pkg::ACC_W-1:0] pt;
      logic signed [SW-1:0]             sum;
      for (int c = 0; c < 3; c++) begin
         s = h3_ff[c] + crs_pkg::ACC_W'(1);
         pt = ctl_ff[6].half ? {s[crs_pkg::ACC_W-1], s[crs_pkg::ACC_W-1:1]} : h3_ff[c];
         sum = SW'(pt) + (ctl_ff[6].nooff ? '0 : SW'(offs[c]));
         if (sum > SAT_HI) begin
            pos_in[c] = SAT_HI[31:0];
         end else if (sum < SAT_LO) begin
            pos_in[c] = SAT_LO[31:0];
         end else begin
            pos_in[c] = sum[31:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f0_ff <= '0;
         f1_ff <= '0;
         ctl_ff <= '{default: '0};
         valid_ff <= 1'b0;
      end else begin
         f0_ff <= f0_in;
         f1_ff <= f0_ff;
         ctl_ff[0] <= c_in;
         for (int s = 1; s < 7; s++) begin
            ctl_ff[s] <= ctl_ff[s-1];
         end
         valid_ff <= ctl_ff[6].v;
      end
   end

   always_ff @(posedge clock) begin
      for (int c = 0; c < 3; c++) begin
         p_ff[c] <= p_in[c];
         a_ff[c] <= a_in[c];
         m1_ff[c] <= crs_pkg::mulu(a_ff[c][3], ctl_ff[0].u);
         m1a_ff[c][0] <= a_ff[c][0];
         m1a_ff[c][1] <= a_ff[c][1];
         m1a_ff[c][2] <= a_ff[c][2];
         h1_ff[c] <= crs_pkg::rnd(m1_ff[c]) + m1a_ff[c][2];
         h1a_ff[c][0] <= m1a_ff[c][0];
         h1a_ff[c][1] <= m1a_ff[c][1];
         m2_ff[c] <= crs_pkg::mulu(h1_ff[c], ctl_ff[2].u);
         m2a_ff[c] <= h1a_ff[c];
         h2_ff[c] <= crs_pkg::rnd(m2_ff[c]) + m2a_ff[c][1];
         h2a_ff[c] <= m2a_ff[c][0];
         m3_ff[c] <= crs_pkg::mulu(h2_ff[c], ctl_ff[4].u);
         m3a_ff[c] <= h2a_ff[c];
         h3_ff[c] <= crs_pkg::rnd(m3_ff[c]) + m3a_ff[c];
         pos_ff[c] <= pos_in[c];
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_pos_x = pos_ff[0];
   assign rsp_pos_y = pos_ff[1];
   assign rsp_pos_z = pos_ff[2];

endmodule

// ===== design/catmull_rom_spline_eval.sv =====
// Uniform 3D Catmull-Rom spline evaluator over a 64-entry node store.
// A request is taken when start is high and busy is low. With req_op set it
// writes req_node_x/y/z into slot req_node_index and gives no response. With
// req_op clear it evaluates the curve at req_param_t (unsigned Q6.16) and
// gives one response on rsp_pos_x/y/z (signed Q16.16, saturated), marked by
// rsp_valid for exactly one cycle. Requests may be issued every cycle; the
// front end classifies a request and places it in a two-entry queue, and
// the back end drains one entry a cycle through a memory read, coefficient
// set-up and a three-step Horner pipeline with one multiplier per lane and
// step. Busy therefore stays low after reset. The receiver cannot stall
// responses, and none is ever held back. Registers must be written through
// csr_valid/csr_ready/csr_index/csr_wdata only while no evaluation is in
// flight; the block does not enforce this. csr_ready is always high.
// Reset clears the registers, the queue and the pipeline, and busy is high
// while reset is asserted. The node store is not cleared; a slot in use must
// be written before it is evaluated.
module catmull_rom_spline_eval (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic                           req_op,
   input  logic [5:0]                     req_node_index,
   input  logic signed [31:0]             req_node_x,
   input  logic signed [31:0]             req_node_y,
   input  logic signed [31:0]             req_node_z,
   input  logic [21:0]                    req_param_t,
   output logic                           rsp_valid,
   output logic signed [31:0]             rsp_pos_x,
   output logic signed [31:0]             rsp_pos_y,
   output logic signed [31:0]             rsp_pos_z,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [crs_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [31:0]                    csr_wdata
);

   logic [crs_pkg::CNT_W-1:0] node_count_ff;
   logic                      line_mode_ff;
   logic                      loop_mode_ff;
   logic signed [31:0]        offset_x_ff;
   logic signed [31:0]        offset_y_ff;
   logic signed [31:0]        offset_z_ff;

   crs_pkg::cmd_type          front_cmd;
   crs_pkg::cmd_type          head_cmd;
   logic                      push;
   logic                      head_valid;
   logic                      q_full;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         node_count_ff <= '0;
         line_mode_ff <= 1'b0;
         loop_mode_ff <= 1'b0;
         offset_x_ff <= '0;
         offset_y_ff <= '0;
         offset_z_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            crs_pkg::CFG_NODE_COUNT: node_count_ff <= csr_wdata[crs_pkg::CNT_W-1:0];
            crs_pkg::CFG_LINE_MODE:  line_mode_ff <= csr_wdata[0];
            crs_pkg::CFG_LOOP_MODE:  loop_mode_ff <= csr_wdata[0];
            crs_pkg::CFG_OFFSET_X:   offset_x_ff <= csr_wdata;
            crs_pkg::CFG_OFFSET_Y:   offset_y_ff <= csr_wdata;
            crs_pkg::CFG_OFFSET_Z:   offset_z_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   crs_front u_front (
      .req_op         (req_op),
      .req_node_index (req_node_index),
      .req_node_x     (req_node_x),
      .req_node_y     (req_node_y),
      .req_node_z     (req_node_z),
      .req_param_t    (req_param_t),
      .node_count     (node_count_ff),
      .line_mode      (line_mode_ff),
      .loop_mode      (loop_mode_ff),
      .cmd            (front_cmd)
   );

   assign busy = reset || q_full;
   assign push = start && !busy;

   crs_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_cmd  (front_cmd),
      .pop       (head_valid),
      .head      (head_cmd),
      .not_empty (head_valid),
      .full      (q_full)
   );

   crs_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop       (head_valid),
      .cmd       (head_cmd),
      .offset_x  (offset_x_ff),
      .offset_y  (offset_y_ff),
      .offset_z  (offset_z_ff),
      .rsp_valid (rsp_valid),
      .rsp_pos_x (rsp_pos_x),
      .rsp_pos_y (rsp_pos_y),
      .rsp_pos_z (rsp_pos_z)
   );

`ifndef SYNTH
   a_never_busy: assert property (@(posedge clock) disable iff (reset) !busy)
      else $error("Request queue filled up.");

   a_rsp_has_request: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy && (req_op == crs_pkg::OP_EVAL), crs_pkg::LAT))
      else $error("Response without a matching evaluate request.");
`endif

endmodule
